/* rtl/pcci_pkg.sv */
// Shared constants and types of the clamped-integrator PID controller.
package pcci_pkg;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int ERR_W      = SAMPLE_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int GAIN_W     = 32;
   localparam int PERIOD_W   = 16;
   localparam int LIMIT_W    = 16;
   localparam int SUM_W      = 30;
   localparam int FRAC_BITS  = 16;
   localparam int TOTAL_W    = 52;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_UPPER   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_LOWER   = 3'd5;

   localparam logic signed [LIMIT_W-1:0] OUT_UPPER_RESET = 16'sh7FFF;
   localparam logic signed [LIMIT_W-1:0] OUT_LOWER_RESET = 16'sh8000;

   // Commands
   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   // Integrator clamp, 5000 in Q16.16
   localparam int SUM_ADD_W = SUM_W + 5;
   localparam logic signed [SUM_ADD_W-1:0] SUM_LIMIT_POS = 35'sd327680000;
   localparam logic signed [SUM_ADD_W-1:0] SUM_LIMIT_NEG = -35'sd327680000;

   // Radix-4 Booth multiplier
   localparam int MCAND_W     = GAIN_W;
   localparam int MPLIER_W    = SUM_W;
   localparam int ACC_W       = MCAND_W + 3;
   localparam int PROD_W      = ACC_W + MPLIER_W;
   localparam int DIGITS_SHORT = 9;
   localparam int DIGITS_LONG  = MPLIER_W / 2;
   localparam int DIGIT_CNT_W  = $clog2(DIGITS_LONG + 1);
   localparam int SHORT_SHIFT  = MPLIER_W - 2 * DIGITS_SHORT;

   typedef struct packed {
      logic                        start;
      logic [DIGIT_CNT_W-1:0]      digits;
      logic signed [MCAND_W-1:0]   mcand;
      logic signed [MPLIER_W-1:0]  mplier;
   } mul_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [PROD_W-1:0]    product;
   } mul_rsp_type;

endpackage

/* rtl/pcci_booth_mul.sv */
// Radix-4 Booth serial multiplier: one two-bit digit of the multiplier per cycle.
module pcci_booth_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  pcci_pkg::mul_req_type mul_req,
   output pcci_pkg::mul_rsp_type mul_rsp
);

   localparam int AW = pcci_pkg::MCAND_W;
   localparam int BW = pcci_pkg::MPLIER_W;
   localparam int HW = pcci_pkg::ACC_W;
   localparam int SW = HW + 1;
   localparam int CW = pcci_pkg::DIGIT_CNT_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [AW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]        mplier_ff, mplier_in;
   logic                 carry_ff, carry_in;
   logic signed [HW-1:0] acc_ff, acc_in;
   logic [BW-1:0]        low_ff, low_in;

   logic [2:0]           booth;
   logic signed [SW-1:0] mcand_ext;
   logic signed [SW-1:0] addend;
   logic signed [SW-1:0] sum;

   // Recode the current digit and add its multiple of the multiplicand
   always_comb begin
      booth     = {mplier_ff[1:0], carry_ff};
      mcand_ext = {{(SW-AW){mcand_ff[AW-1]}}, mcand_ff};
      case (booth) inside
         3'b001, 3'b010: addend = mcand_ext;
         3'b011:         addend = mcand_ext <<< 1;
         3'b100:         addend = -(mcand_ext <<< 1);
         3'b101, 3'b110: addend = -mcand_ext;
         default:        addend = '0;
      endcase
      sum = {acc_ff[HW-1], acc_ff} + addend;
   end

   // Next state: load on start, shift two product bits out per digit
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      carry_in  = carry_ff;
      acc_in    = acc_ff;
      low_in    = low_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         count_in  = mul_req.digits;
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
         carry_in  = 1'b0;
         acc_in    = '0;
         low_in    = '0;
      end else if (busy_ff) begin
         count_in  = count_ff - CW'(1);
         mplier_in = {{2{mplier_ff[BW-1]}}, mplier_ff[BW-1:2]};
         carry_in  = mplier_ff[1];
         acc_in    = {sum[SW-1], sum[SW-1:2]};
         low_in    = {sum[1:0], low_ff[BW-1:2]};
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      carry_ff  <= carry_in;
      acc_ff    <= acc_in;
      low_ff    <= low_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = {acc_ff, low_ff};

endmodule

/* rtl/pid_controller_clamped_integrator_unit.sv */
// PID control step with clamped integrator over a shared serial Booth multiplier.
// An item is accepted only while the unit is idle, so the next item waits until the result
// of the last one is in the result register. The four products (error times period,
// proportional, derivative, integral) run one after another.
// A reset command skips the products and yields a zero drive, not saturated.
// Synchronous reset clears the gains, period, previous error and error sum and restores
// the full output range.
module pid_controller_clamped_integrator_unit (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] reference, [31:16] feedback
   input  logic        req_tuser,   // [0] command
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] drive
   output logic        rsp_tuser,   // [0] output_saturated
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pcci_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcci_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int EW = pcci_pkg::ERR_W;
   localparam int DW = pcci_pkg::DIFF_W;
   localparam int GW = pcci_pkg::GAIN_W;
   localparam int PW = pcci_pkg::PERIOD_W;
   localparam int LW = pcci_pkg::LIMIT_W;
   localparam int SW = pcci_pkg::SUM_W;
   localparam int AW = pcci_pkg::SUM_ADD_W;
   localparam int TW = pcci_pkg::TOTAL_W;
   localparam int BW = pcci_pkg::MPLIER_W;
   localparam int FB = pcci_pkg::FRAC_BITS;
   localparam int XW = pcci_pkg::PROD_W;
   localparam int SH = pcci_pkg::SHORT_SHIFT;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL_SUM = 3'd1;
   localparam logic [2:0] S_MUL_P   = 3'd2;
   localparam logic [2:0] S_MUL_D   = 3'd3;
   localparam logic [2:0] S_MUL_I   = 3'd4;
   localparam logic [2:0] S_OUT     = 3'd5;

   // Configuration registers
   logic signed [GW-1:0] kp_ff, kp_in;
   logic signed [GW-1:0] ki_ff, ki_in;
   logic signed [GW-1:0] kdp_ff, kdp_in;
   logic [PW-1:0]        period_ff, period_in;
   logic signed [LW-1:0] upper_ff, upper_in;
   logic signed [LW-1:0] lower_ff, lower_in;

   // Controller state and sequencer
   logic [2:0]           state_ff, state_in;
   logic signed [EW-1:0] prev_ff, prev_in;
   logic signed [SW-1:0] esum_ff, esum_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic signed [TW-1:0] total_ff, total_in;
   logic                 zero_ff, zero_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [LW-1:0] rsp_drive_ff, rsp_drive_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   pcci_pkg::mul_req_type mul_req;
   pcci_pkg::mul_rsp_type mul_rsp;

   logic                 req_accept;
   logic                 out_free;
   logic signed [EW-1:0] err_new;
   logic signed [DW-1:0] diff;
   logic signed [TW-1:0] prod_short;
   logic signed [TW-1:0] prod_frac;
   logic signed [AW-1:0] sum_raw;
   logic signed [SW-1:0] sum_clamped;
   logic signed [TW-1:0] upper_q;
   logic signed [TW-1:0] lower_q;
   logic signed [LW-1:0] drive;
   logic                 sat;

   pcci_booth_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Error and derivative difference
   always_comb begin
      err_new = {req_tdata[pcci_pkg::SAMPLE_W-1], req_tdata[15:0]}
              - {req_tdata[31], req_tdata[31:16]};
      diff    = {err_ff[EW-1], err_ff} - {prev_ff[EW-1], prev_ff};
   end

   // Align products and clamp the error sum: short runs leave their low bits above a zero gap
   always_comb begin
      prod_short  = mul_rsp.product[TW+SH-1:SH];
      prod_frac   = {{(TW-(XW-FB)){mul_rsp.product[XW-1]}}, mul_rsp.product[XW-1:FB]};
      sum_raw     = {{(AW-SW){esum_ff[SW-1]}}, esum_ff} + mul_rsp.product[AW+SH-1:SH];
      if (sum_raw > pcci_pkg::SUM_LIMIT_POS) begin
         sum_clamped = pcci_pkg::SUM_LIMIT_POS[SW-1:0];
      end else if (sum_raw < pcci_pkg::SUM_LIMIT_NEG) begin
         sum_clamped = pcci_pkg::SUM_LIMIT_NEG[SW-1:0];
      end else begin
         sum_clamped = sum_raw[SW-1:0];
      end
   end

   // Clamp the total to the output limits; a reset command gives a zero drive
   always_comb begin
      upper_q = {{(TW-LW-FB){upper_ff[LW-1]}}, upper_ff, {FB{1'b0}}};
      lower_q = {{(TW-LW-FB){lower_ff[LW-1]}}, lower_ff, {FB{1'b0}}};
      if (zero_ff) begin
         drive = '0;
         sat   = 1'b0;
      end else if (total_ff > upper_q) begin
         drive = upper_ff;
         sat   = 1'b1;
      end else if (total_ff < lower_q) begin
         drive = lower_ff;
         sat   = 1'b1;
      end else begin
         drive = total_ff[FB+LW-1:FB];
         sat   = 1'b0;
      end
   end

   // Multiplier requests, one product after another
   always_comb begin
      mul_req        = '0;
      mul_req.digits = pcci_pkg::DIGIT_CNT_W'(pcci_pkg::DIGITS_SHORT);
      unique case (state_ff) inside
         S_IDLE: begin
            mul_req.start  = req_accept && (req_tuser == pcci_pkg::CMD_STEP);
            mul_req.mcand  = {{(GW-EW){err_new[EW-1]}}, err_new};
            mul_req.mplier = {{(BW-PW){1'b0}}, period_ff};
         end
         S_MUL_SUM: begin
            mul_req.start  = mul_rsp.done;
            mul_req.mcand  = kp_ff;
            mul_req.mplier = {{(BW-EW){err_ff[EW-1]}}, err_ff};
         end
         S_MUL_P: begin
            mul_req.start  = mul_rsp.done;
            mul_req.mcand  = kdp_ff;
            mul_req.mplier = {{(BW-DW){diff[DW-1]}}, diff};
         end
         S_MUL_D: begin
            mul_req.start  = mul_rsp.done;
            mul_req.digits = pcci_pkg::DIGIT_CNT_W'(pcci_pkg::DIGITS_LONG);
            mul_req.mcand  = ki_ff;
            mul_req.mplier = esum_ff;
         end
         S_MUL_I, S_OUT: begin
            mul_req.start  = 1'b0;
         end
         default: begin
            mul_req.start  = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      esum_in      = esum_ff;
      err_in       = err_ff;
      total_in     = total_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == pcci_pkg::CMD_RESET) begin
                  prev_in  = '0;
                  zero_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  err_in   = err_new;
                  zero_in  = 1'b0;
                  state_in = S_MUL_SUM;
               end
            end
         end
         S_MUL_SUM: begin
            if (mul_rsp.done) begin
               esum_in  = sum_clamped;
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            if (mul_rsp.done) begin
               total_in = prod_short;
               state_in = S_MUL_D;
            end
         end
         S_MUL_D: begin
            if (mul_rsp.done) begin
               total_in = total_ff + prod_short;
               state_in = S_MUL_I;
            end
         end
         S_MUL_I: begin
            if (mul_rsp.done) begin
               total_in = total_ff + prod_frac;
               prev_in  = err_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive;
               rsp_sat_in   = sat;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration write decode
   always_comb begin
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kdp_in    = kdp_ff;
      period_in = period_ff;
      upper_in  = upper_ff;
      lower_in  = lower_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcci_pkg::REG_PROP_GAIN:  kp_in     = csr_data[GW-1:0];
            pcci_pkg::REG_INTEG_GAIN: ki_in     = csr_data[GW-1:0];
            pcci_pkg::REG_DERIV_GAIN: kdp_in    = csr_data[GW-1:0];
            pcci_pkg::REG_PERIOD:     period_in = csr_data[PW-1:0];
            pcci_pkg::REG_OUT_UPPER:  upper_in  = csr_data[LW-1:0];
            pcci_pkg::REG_OUT_LOWER:  lower_in  = csr_data[LW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         esum_ff      <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kdp_ff       <= '0;
         period_ff    <= '0;
         upper_ff     <= pcci_pkg::OUT_UPPER_RESET;
         lower_ff     <= pcci_pkg::OUT_LOWER_RESET;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         esum_ff      <= esum_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kdp_ff       <= kdp_in;
         period_ff    <= period_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
      end
   end

   // Hold datapath and result payload
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      total_ff     <= total_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* tb/pid_controller_clamped_integrator_unit_test.sv */
// Self-checking bench for the clamped-integrator PID controller: directed table, then random phases.
module pid_controller_clamped_integrator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 60;

   localparam int IW = pcci_pkg::CSR_INDEX_W;
   localparam int CW = pcci_pkg::CSR_DATA_W;

   localparam logic STEP = pcci_pkg::CMD_STEP;
   localparam logic RST  = pcci_pkg::CMD_RESET;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               sat;
   } drive_res_type;

   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kdp;
      logic [15:0]        period;
      logic signed [15:0] upper;
      logic signed [15:0] lower;
   } ctrl_cfg_type;

   typedef struct packed {
      logic [2:0]         setting;
      logic               cmd;
      logic signed [15:0] target;
      logic signed [15:0] measured;
      logic               fixed;
      logic signed [15:0] drive;
      logic               sat;
   } dir_row_type;

   // Settings used by the directed table; entry 0 is the state after reset
   localparam ctrl_cfg_type DIR_CFGS [6] = '{
      '{32'sh0, 32'sh0, 32'sh0, 16'h0, 16'sh7FFF, 16'sh8000},
      '{32'sh00010000, 32'sh0, 32'sh0, 16'h0, 16'sh7FFF, 16'sh8000},
      '{32'sh00008000, 32'sh00010000, 32'sh00004000, 16'h0CCD, 16'sd1000, -16'sd1000},
      '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 16'hFFFF, 16'sh7FFF, 16'sh8000},
      '{32'sh00010000, 32'sh0, 32'sh0, 16'h0, -16'sd10, 16'sd10},
      '{32'sh0, 32'sh00020000, 32'shFFFF0000, 16'h0, 16'sh7FFF, 16'sh8000}
   };

   localparam dir_row_type DIRECTED [24] = '{
      // gains still zero after reset
      '{3'd0, STEP, 16'sd1000,  -16'sd1000, 1'b1, 16'sd0, 1'b0},
      '{3'd0, STEP, 16'sh7FFF,  16'sh8000,  1'b1, 16'sd0, 1'b0},
      '{3'd0, RST,  16'sd0,     16'sd0,     1'b1, 16'sd0, 1'b0},
      // unit proportional gain: within, above and below the limits
      '{3'd1, STEP, 16'sd100,   16'sd40,    1'b1, 16'sd60, 1'b0},
      '{3'd1, STEP, 16'sh7FFF,  16'sh8000,  1'b1, 16'sh7FFF, 1'b1},
      '{3'd1, STEP, 16'sh8000,  16'sh7FFF,  1'b1, 16'sh8000, 1'b1},
      '{3'd1, STEP, -16'sd5,    16'sd0,     1'b1, -16'sd5, 1'b0},
      '{3'd1, RST,  16'sh8000,  16'sh8000,  1'b1, 16'sd0, 1'b0},
      // all three terms active
      '{3'd2, STEP, 16'sd300,   16'sd0,     1'b0, 16'sd0, 1'b0},
      '{3'd2, STEP, 16'sd300,   16'sd100,   1'b0, 16'sd0, 1'b0},
      '{3'd2, STEP, -16'sd200,  16'sd200,   1'b0, 16'sd0, 1'b0},
      '{3'd2, RST,  16'sd123,   -16'sd456,  1'b1, 16'sd0, 1'b0},
      '{3'd2, STEP, 16'sd50,    16'sd60,    1'b0, 16'sd0, 1'b0},
      '{3'd2, STEP, -16'sd1,    16'sd0,     1'b0, 16'sd0, 1'b0},
      // extreme gains and period, integrator runs into its clamp
      '{3'd3, STEP, 16'sh7FFF,  16'sh8000,  1'b0, 16'sd0, 1'b0},
      '{3'd3, STEP, 16'sh7FFF,  16'sh8000,  1'b0, 16'sd0, 1'b0},
      '{3'd3, STEP, 16'sh8000,  16'sh7FFF,  1'b0, 16'sd0, 1'b0},
      '{3'd3, STEP, 16'sd0,     16'sd0,     1'b0, 16'sd0, 1'b0},
      // crossed limits: upper test wins first
      '{3'd4, STEP, 16'sd0,     16'sd0,     1'b1, -16'sd10, 1'b1},
      '{3'd4, STEP, -16'sd20,   16'sd0,     1'b1, 16'sd10, 1'b1},
      // zero period: integral held, derivative from register only
      '{3'd5, STEP, 16'sd500,   16'sd0,     1'b0, 16'sd0, 1'b0},
      '{3'd5, STEP, 16'sd400,   16'sd0,     1'b0, 16'sd0, 1'b0},
      '{3'd5, RST,  16'sd0,     16'sd0,     1'b1, 16'sd0, 1'b0},
      '{3'd5, STEP, 16'sd400,   16'sd0,     1'b0, 16'sd0, 1'b0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;
   logic          req_tuser = STEP;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [IW-1:0] csr_index = pcci_pkg::REG_PROP_GAIN;
   logic [CW-1:0] csr_data = '0;

   // Controller copy: configuration and loop state
   logic signed [31:0] kp_reg = '0;
   logic signed [31:0] ki_reg = '0;
   logic signed [31:0] kdp_reg = '0;
   logic [15:0]        period_reg = '0;
   logic signed [15:0] upper_reg = pcci_pkg::OUT_UPPER_RESET;
   logic signed [15:0] lower_reg = pcci_pkg::OUT_LOWER_RESET;
   longint             prev_err = 0;
   longint             err_sum = 0;

   drive_res_type pending_drives [$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  rsp_stall_on = 1'b1;
   bit  req_gap_on = 1'b1;

   pid_controller_clamped_integrator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // One control step of the controller copy
   function automatic drive_res_type next_drive(logic cmd, logic signed [15:0] target,
                                                logic signed [15:0] measured);
      longint        lim;
      longint        err;
      longint        total;
      drive_res_type res;
      lim = longint'(5000) * 65536;
      res = '0;
      if (cmd == RST) begin
         prev_err = 0;
         return res;
      end
      err = longint'(target) - longint'(measured);
      err_sum = err_sum + err * longint'(period_reg);
      if (err_sum > lim) begin
         err_sum = lim;
      end else if (err_sum < -lim) begin
         err_sum = -lim;
      end
      total = longint'(kp_reg) * err
            + ((longint'(ki_reg) * err_sum) >>> 16)
            + longint'(kdp_reg) * (err - prev_err);
      if (total > longint'(upper_reg) * 65536) begin
         res.drive = upper_reg;
         res.sat = 1'b1;
      end else if (total < longint'(lower_reg) * 65536) begin
         res.drive = lower_reg;
         res.sat = 1'b1;
      end else begin
         res.drive = 16'(total >>> 16);
      end
      prev_err = err;
      return res;
   endfunction

   // Compare one result item with the oldest expectation
   function automatic void check_drive(logic [15:0] drive, logic sat);
      drive_res_type want;
      if (pending_drives.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result item: drive %0d sat %0b", $signed(drive), sat);
         return;
      end
      want = pending_drives.pop_front();
      if (drive !== want.drive || sat !== want.sat) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                     want.drive, want.sat, $signed(drive), sat);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] rand_gain(int span);
      return 32'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic signed [31:0] extreme_gain();
      case ($urandom_range(0, 2))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         default: return 32'sh0;
      endcase
   endfunction

   function automatic logic signed [15:0] extreme_sample();
      case ($urandom_range(0, 4))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd1;
         3: return -16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return 16'(int'($urandom_range(0, 4000)) - 2000);
      if (r < 8)
         return 16'($urandom);
      return extreme_sample();
   endfunction

   // Mostly moderate gains so the output stays within limits, some full range and extremes
   function automatic ctrl_cfg_type random_cfg();
      ctrl_cfg_type c;
      int           k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         c.kp = rand_gain(32'h40000);
         c.ki = rand_gain(32'h20000);
         c.kdp = rand_gain(32'h10000);
         c.period = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
         c.upper = 16'($urandom_range(0, 32767));
         c.lower = 16'(0 - int'($urandom_range(0, 32768)));
      end else if (k < 8) begin
         c.kp = 32'($urandom);
         c.ki = 32'($urandom);
         c.kdp = 32'($urandom);
         c.period = 16'($urandom);
         c.upper = 16'($urandom);
         c.lower = 16'($urandom);
      end else begin
         c.kp = extreme_gain();
         c.ki = extreme_gain();
         c.kdp = extreme_gain();
         c.period = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
         c.upper = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         c.lower = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      return c;
   endfunction

   // Write one register; leave csr_valid high for the caller
   task automatic write_reg(logic [IW-1:0] index, logic [CW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pcci_pkg::REG_PROP_GAIN:  kp_reg = data;
         pcci_pkg::REG_INTEG_GAIN: ki_reg = data;
         pcci_pkg::REG_DERIV_GAIN: kdp_reg = data;
         pcci_pkg::REG_PERIOD:     period_reg = data[15:0];
         pcci_pkg::REG_OUT_UPPER:  upper_reg = data[15:0];
         pcci_pkg::REG_OUT_LOWER:  lower_reg = data[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(ctrl_cfg_type c);
      write_reg(pcci_pkg::REG_PROP_GAIN, c.kp);
      write_reg(pcci_pkg::REG_INTEG_GAIN, c.ki);
      write_reg(pcci_pkg::REG_DERIV_GAIN, c.kdp);
      write_reg(pcci_pkg::REG_PERIOD, {16'h0, c.period});
      write_reg(pcci_pkg::REG_OUT_UPPER, {16'h0, c.upper});
      write_reg(pcci_pkg::REG_OUT_LOWER, {16'h0, c.lower});
      csr_valid <= 1'b0;
   endtask

   // Hold the input and wait until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
   endtask

   // Offer one item, record its expected result on acceptance
   task automatic send_item(logic cmd, logic signed [15:0] target,
                            logic signed [15:0] measured, logic fixed,
                            drive_res_type fixed_res);
      drive_res_type res;
      int            gap;
      gap = (req_gap_on && $urandom_range(0, 99) < 45) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {measured, target};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      res = next_drive(cmd, target, measured);
      pending_drives.push_back(fixed ? fixed_res : res);
   endtask

   // Result side: check accepted items, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_drive(rsp_tdata, rsp_tuser);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [2:0]         cur_setting;
      int                 sent;
      int                 n;
      logic               cmd;
      logic signed [15:0] target;
      logic signed [15:0] measured;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      cur_setting = 3'd0;
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].setting != cur_setting) begin
            wait_drained();
            cur_setting = DIRECTED[i].setting;
            apply_config(DIR_CFGS[cur_setting]);
         end
         send_item(DIRECTED[i].cmd, DIRECTED[i].target, DIRECTED[i].measured,
                   DIRECTED[i].fixed, drive_res_type'{DIRECTED[i].drive, DIRECTED[i].sat});
      end

      // Random phases, each under a fresh setting
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         apply_config(random_cfg());
         req_gap_on = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(30, 110);
         for (int i = 0; i < n && sent < RANDOM_ITEMS; i++) begin
            cmd = ($urandom_range(0, 99) < 8) ? RST : STEP;
            target = rand_sample();
            if ($urandom_range(0, 9) < 3)
               measured = target + 16'(int'($urandom_range(0, 100)) - 50);
            else
               measured = rand_sample();
            send_item(cmd, target, measured, 1'b0, '0);
            sent++;
            if ($urandom_range(0, 49) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_drives.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
